// ===== hw/rtl/tpnc_pkg.sv =====
// Shared widths, codes and transaction types for the tree path node counter.
`default_nettype none

package tpnc_pkg;

  localparam int ID_W       = 10;
  localparam int STEP_W     = 10;
  localparam int PATH_W     = 11;
  localparam int STATUS_W   = 2;
  localparam int EPOCH_W    = 8;
  localparam int TAB_DEPTH  = 1 << ID_W;
  localparam int CHAIN_LIMIT   = TAB_DEPTH - 1;
  localparam int MAX_NODES_DEF = 1023;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOANC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BOUND = 2'd2;

  typedef struct packed {
    logic            op;
    logic [ID_W-1:0] first_node;
    logic [ID_W-1:0] second_node;
  } req_t;

  typedef struct packed {
    logic [PATH_W-1:0]   path_nodes;
    logic [STATUS_W-1:0] status;
  } res_t;

  // One ancestor mark: valid only while its tag equals the current epoch.
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [STEP_W-1:0]  depth;
  } mark_t;

  typedef struct packed {
    logic load_we;
    logic latch;
    logic walk1;
    logic walk2;
    logic sweep_parent;
    logic sweep_mark;
    logic epoch_step;
  } cmd_t;

  typedef struct packed {
    logic walk1_end;
    logic walk1_fail;
    logic walk2_end;
    logic sweep_last;
    logic epoch_last;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tpnc_dp.sv =====
// Datapath: parent table, epoch-tagged mark table, walk registers and result.
`default_nettype none

module tpnc_dp
  import tpnc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire req_t  request,
  input  wire cmd_t  cmd,
  output stat_t      stat,
  output res_t       result
);

  localparam int WALK_BOUND = (MAX_NODES < CHAIN_LIMIT) ? MAX_NODES : CHAIN_LIMIT;
  localparam logic [STEP_W-1:0] BOUND_W = STEP_W'(WALK_BOUND);

  logic [ID_W-1:0]    ptab [TAB_DEPTH];
  mark_t              mtab [TAB_DEPTH];
  logic [ID_W-1:0]    ptab_q;
  mark_t              mtab_q;

  logic [ID_W-1:0]    node_a;
  logic [ID_W-1:0]    node_b;
  logic [STEP_W-1:0]  step;
  logic               fresh;
  logic               prev_valid;
  logic [EPOCH_W-1:0] epoch;
  logic [ID_W-1:0]    sweep;

  logic [ID_W-1:0]    cur;
  logic               at_bound;
  logic               hit;
  logic               w1_end;
  logic               w2_end;
  logic               advance;
  logic [STEP_W-1:0]  step_inc;

  logic               ptab_we;
  logic [ID_W-1:0]    ptab_wa;
  logic [ID_W-1:0]    ptab_wd;
  logic               mtab_we;
  logic [ID_W-1:0]    mtab_wa;
  mark_t              mtab_wd;

  always_comb begin
    cur      = fresh ? (cmd.walk1 ? node_a : node_b) : ptab_q;
    at_bound = (step >= BOUND_W);
    hit      = prev_valid && (mtab_q.tag == epoch);
    w1_end   = (cur == '0) || at_bound;
    w2_end   = hit || (cur == '0) || at_bound;
    advance  = (cmd.walk1 && !w1_end) || (cmd.walk2 && !w2_end);
    step_inc = step + STEP_W'(1);
  end

  always_comb begin
    stat.walk1_end  = w1_end;
    stat.walk1_fail = (cur != '0) && at_bound;
    stat.walk2_end  = w2_end;
    stat.sweep_last = (sweep == '1);
    stat.epoch_last = (epoch == '1);
  end

  // Memory write ports: sweeps take priority, they only run while idle otherwise.
  always_comb begin
    ptab_we = cmd.load_we || cmd.sweep_parent;
    ptab_wa = cmd.sweep_parent ? sweep : request.second_node;
    ptab_wd = cmd.sweep_parent ? '0 : request.first_node;
    mtab_we = (cmd.walk1 && !w1_end) || cmd.sweep_mark;
    mtab_wa = cmd.sweep_mark ? sweep : cur;
    mtab_wd = cmd.sweep_mark ? '0 : {epoch, step_inc};
  end

  always_ff @(posedge clk) begin
    if (ptab_we) begin
      ptab[ptab_wa] <= ptab_wd;
    end
    ptab_q <= ptab[cur];
  end

  always_ff @(posedge clk) begin
    if (mtab_we) begin
      mtab[mtab_wa] <= mtab_wd;
    end
    mtab_q <= mtab[cur];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh      <= 1'b0;
      prev_valid <= 1'b0;
      step       <= '0;
      epoch      <= EPOCH_W'(1);
      sweep      <= '0;
    end else begin
      if (cmd.latch) begin
        fresh      <= 1'b1;
        prev_valid <= 1'b0;
        step       <= '0;
      end else if (cmd.walk1) begin
        if (w1_end) begin
          // rearm for the second walk
          fresh <= 1'b1;
          step  <= '0;
        end else begin
          fresh <= 1'b0;
          step  <= step_inc;
        end
      end else if (cmd.walk2) begin
        fresh <= 1'b0;
        if (advance) begin
          step       <= step_inc;
          prev_valid <= 1'b1;
        end
      end
      if (cmd.epoch_step) begin
        // skip tag zero: swept entries carry it
        epoch <= (epoch == '1) ? EPOCH_W'(1) : epoch + EPOCH_W'(1);
      end
      if (cmd.sweep_parent || cmd.sweep_mark) begin
        sweep <= sweep + ID_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      node_a <= request.first_node;
      node_b <= request.second_node;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk1 && w1_end) begin
      result.path_nodes <= '0;
      result.status     <= ST_BOUND;
    end else if (cmd.walk2 && w2_end) begin
      priority if (hit) begin
        result.path_nodes <= PATH_W'(step) + PATH_W'(mtab_q.depth) - PATH_W'(1);
        result.status     <= ST_OK;
      end else if (cur == '0) begin
        result.path_nodes <= (step == '0) ? '0 : PATH_W'(step) - PATH_W'(1);
        result.status     <= ST_NOANC;
      end else begin
        result.path_nodes <= '0;
        result.status     <= ST_BOUND;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tpnc_ctrl.sv =====
// Controller: sequences clearing passes, loads and the two walks of a query.
`default_nettype none

module tpnc_ctrl
  import tpnc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire logic  op,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       busy,
  output logic       done
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK1 = 3'd2;
  localparam logic [2:0] S_WALK2 = 3'd3;
  localparam logic [2:0] S_WIPE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       done_next;
  logic [2:0] after_query;

  always_comb begin
    cmd         = '0;
    state_next  = state;
    done_next   = 1'b0;
    after_query = stat.epoch_last ? S_WIPE : S_IDLE;
    unique case (state)
      S_CLEAR: begin
        cmd.sweep_parent = 1'b1;
        cmd.sweep_mark   = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (op == OP_LOAD) begin
            cmd.load_we = 1'b1;
          end else begin
            cmd.latch  = 1'b1;
            state_next = S_WALK1;
          end
        end
      end
      S_WALK1: begin
        cmd.walk1 = 1'b1;
        if (stat.walk1_end) begin
          if (stat.walk1_fail) begin
            done_next      = 1'b1;
            cmd.epoch_step = 1'b1;
            state_next     = after_query;
          end else begin
            state_next = S_WALK2;
          end
        end
      end
      S_WALK2: begin
        cmd.walk2 = 1'b1;
        if (stat.walk2_end) begin
          done_next      = 1'b1;
          cmd.epoch_step = 1'b1;
          state_next     = after_query;
        end
      end
      S_WIPE: begin
        cmd.sweep_mark = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/tree_path_node_count.sv =====
// Tree path node counter: parent table loads and path queries between node pairs.
// A transaction is taken when start is high and busy is low. A load writes one
// parent entry in that cycle and leaves busy low. A query walks up from the
// first node one parent-table read per cycle, marking ancestors, then walks up
// from the second node the same way until it meets a mark, a root or the walk
// bound, which is min(MAX_NODES, 1023) nodes; a bound hit in the first walk
// ends the query. The result appears with done for one cycle; busy drops in
// that same cycle unless a mark wipe follows; the receiver cannot stall it, so
// sample it then. After reset busy stays high while both tables are cleared;
// marks carry 8-bit epoch tags, so every 255th query adds a busy mark wipe.
`default_nettype none

module tree_path_node_count
  import tpnc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t request,
  output logic      busy,
  output logic      done,
  output res_t      result
);

  cmd_t  cmd;
  stat_t stat;

  tpnc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (request.op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  tpnc_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a query in progress");

  a_query_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.op == OP_QUERY) |=> busy)
    else $error("accepted query did not start a walk");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.op == OP_LOAD) |=> !done)
    else $error("load transaction produced a result");

  a_bound_zero_path: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_BOUND) |-> (result.path_nodes == '0))
    else $error("bound failure with nonzero path count");

endmodule

`default_nettype wire

// ===== tb/tb_tree_path_node_count.sv =====
// Self-checking testbench for the tree path node counter: directed and random loads and queries.
`default_nettype none

module tb_tree_path_node_count
  import tpnc_pkg::*;
();

  class path_checker;
    logic [ID_W-1:0] parent_of [TAB_DEPTH];
    res_t            awaited_paths[$];
    int unsigned     walk_limit;
    int unsigned     failures;

    function new(int unsigned max_nodes);
      walk_limit = (max_nodes < CHAIN_LIMIT) ? max_nodes : CHAIN_LIMIT;
      failures   = 0;
      foreach (parent_of[i]) parent_of[i] = '0;
    endfunction

    // Mark the ancestors of a, then climb from b until a mark, a root or the walk limit is met.
    function res_t trace_path(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
      int unsigned     mark_dist [TAB_DEPTH];
      logic [ID_W-1:0] node;
      int unsigned     steps;
      bit              met;
      res_t            r;
      foreach (mark_dist[i]) mark_dist[i] = 0;
      r.status     = ST_OK;
      r.path_nodes = '0;
      met          = 1'b0;
      node         = a;
      steps        = 0;
      while (node != '0) begin
        if (steps >= walk_limit) begin
          r.status = ST_BOUND;
          break;
        end
        steps++;
        mark_dist[node] = steps;
        node = parent_of[node];
      end
      if (r.status == ST_OK) begin
        node  = b;
        steps = 0;
        while (node != '0) begin
          if (steps >= walk_limit) begin
            r.status = ST_BOUND;
            break;
          end
          steps++;
          if (mark_dist[node] != 0) begin
            r.path_nodes = PATH_W'(steps + mark_dist[node] - 1);
            met = 1'b1;
            break;
          end
          node = parent_of[node];
        end
        if (r.status == ST_OK && !met) begin
          r.status     = ST_NOANC;
          r.path_nodes = (steps != 0) ? PATH_W'(steps - 1) : '0;
        end
      end
      if (r.status == ST_BOUND) r.path_nodes = '0;
      return r;
    endfunction

    function void note_request(req_t r);
      if (r.op == OP_LOAD) parent_of[r.second_node] = r.first_node;
      else awaited_paths = {awaited_paths, trace_path(r.first_node, r.second_node)};
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (awaited_paths.size() == 0) begin
        $error("result with nothing awaited: path_nodes=%0d status=%0d",
               got.path_nodes, got.status);
        failures++;
        return;
      end
      want = awaited_paths.pop_front();
      if (got.path_nodes !== want.path_nodes) begin
        $error("path_nodes: expected %0d, actual %0d", want.path_nodes, got.path_nodes);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return awaited_paths.size();
    endfunction
  endclass

  localparam int QUIET_LIMIT  = 20000;
  localparam int SETTLE       = 64;
  localparam int QUERY_TARGET = 256;

  logic clk     = 1'b0;
  logic rst     = 1'b1;
  logic start   = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  res_t result;

  path_checker board = new(MAX_NODES_DEF);

  int          quiet_cycles = 0;
  int unsigned burst_left   = 0;
  int unsigned queries_sent = 0;

  tree_path_node_count #(.MAX_NODES(MAX_NODES_DEF)) u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic req_t link_req(logic [ID_W-1:0] parent, logic [ID_W-1:0] child);
    req_t r;
    r.op          = OP_LOAD;
    r.first_node  = parent;
    r.second_node = child;
    return r;
  endfunction

  function automatic req_t ask_req(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
    req_t r;
    r.op          = OP_QUERY;
    r.first_node  = a;
    r.second_node = b;
    return r;
  endfunction

  // Send in bursts of random length; hold start until the block takes the transaction.
  task automatic send_item(input req_t r);
    if (burst_left == 0) begin
      start   <= 1'b0;
      request <= req_t'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 6);
    end
    burst_left--;
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(r);
    if (r.op == OP_QUERY) queries_sent++;
  endtask

  task automatic wait_for_results();
    start      <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Build a forest inside a 16-id window, then query mostly within it.
  task automatic run_round();
    int unsigned     base;
    int unsigned     n_links;
    int unsigned     n_asks;
    int unsigned     pick;
    logic [ID_W-1:0] child;
    logic [ID_W-1:0] parent;
    logic [ID_W-1:0] a;
    logic [ID_W-1:0] b;
    base    = $urandom_range(1, TAB_DEPTH - 65);
    n_links = $urandom_range(3, 6);
    n_asks  = $urandom_range(40, 70);
    repeat (n_links) begin
      child = ID_W'(base + $urandom_range(1, 15));
      pick  = $urandom_range(0, 9);
      if (pick == 0)      parent = '0;
      else if (pick <= 5) parent = child - 1'b1;
      else if (pick <= 8) parent = ID_W'(base + $urandom_range(0, child - base - 1));
      else                parent = ID_W'($urandom);
      send_item(link_req(parent, child));
    end
    repeat (n_asks) begin
      if (queries_sent >= QUERY_TARGET) break;
      pick = $urandom_range(0, 19);
      a = ID_W'(base + $urandom_range(0, 15));
      b = ID_W'(base + $urandom_range(0, 15));
      if (pick == 0) a = '0;
      else if (pick == 1) b = '0;
      else if (pick == 2) begin
        a = ID_W'($urandom);
        b = ID_W'($urandom);
      end
      // re-parent a node now and then while queries run
      if (pick == 3) send_item(link_req(ID_W'(base + $urandom_range(0, 15)), b));
      else send_item(ask_req(a, b));
    end
    if ($urandom_range(0, 1) == 0) wait_for_results();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (done) board.check_result(result);
      if (done || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_item(ask_req(10'd0, 10'd0));
    send_item(ask_req(10'd1023, 10'd1023));
    send_item(link_req(10'd1023, 10'd0));     // entry of node zero is never read
    send_item(link_req(10'd1023, 10'd512));
    send_item(link_req(10'd512, 10'd1));
    send_item(link_req(10'd512, 10'd2));
    send_item(link_req(10'd1023, 10'd1022));
    send_item(ask_req(10'd1, 10'd2));
    send_item(ask_req(10'd1, 10'd1022));
    send_item(ask_req(10'd1, 10'd1023));
    send_item(ask_req(10'd0, 10'd1));
    send_item(ask_req(10'd2, 10'd0));
    send_item(ask_req(10'd1, 10'd700));
    // two-node loop: first walk fails, then second walk fails
    send_item(link_req(10'd6, 10'd5));
    send_item(link_req(10'd5, 10'd6));
    send_item(ask_req(10'd5, 10'd1));
    send_item(ask_req(10'd1, 10'd6));
    send_item(link_req(10'd341, 10'd341));
    send_item(ask_req(10'd682, 10'd341));
    send_item(link_req(10'd0, 10'd5));
    send_item(link_req(10'd0, 10'd341));
    send_item(ask_req(10'd341, 10'd682));
    wait_for_results();

    // run past the mark epoch wrap at least once
    while (queries_sent < QUERY_TARGET) run_round();

    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
